/* design/jcpr_pkg.sv */
`timescale 1ns / 1ps
package jcpr_pkg;
    localparam int OneQ30Sh = 30;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_SQRT = 2'd1,
        OP_DIV  = 2'd2
    } unit_op_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_SCALE   = 4'd1,
        ST_SQ      = 4'd2,
        ST_SQRT1   = 4'd3,
        ST_DIV1    = 4'd4,
        ST_TSQ     = 4'd5,
        ST_SQRT2   = 4'd6,
        ST_DIV2    = 4'd7,
        ST_SIN     = 4'd8,
        ST_RD      = 4'd9,
        ST_MJ      = 4'd10,
        ST_MK      = 4'd11,
        ST_OUT     = 4'd12,
        ST_EMPTY   = 4'd13,
        ST_WAIT    = 4'd14,
        ST_NORM    = 4'd15
    } state_t;

    typedef struct packed {
        unit_op_t   op;
        logic       start;
    } unit_ctl_t;

    typedef struct packed {
        logic       busy;
        logic       done;
    } unit_sts_t;

    function automatic logic signed [63:0] round30(input logic signed [63:0] v);
        logic [63:0] m;
        begin
            m = v[63] ? (64'd0 - v) : v;
            m = (m + 64'd536870912) >> OneQ30Sh;
            round30 = v[63] ? -$signed(m) : $signed(m);
        end
    endfunction
endpackage

/* design/jacobi_column_pair_rotation.sv */
`timescale 1ns / 1ps
// Load request: accepted back to back.
// Rotate request: setup (operand scaling, up to two sqrt and two divides on one shared
// bit-serial unit; a zero cross term skips the first sqrt and divide), then per stored
// pair RD, MJ, WAIT, MK, EMPTY, OUT on one shared multiplier and the registered read.
// A rotate with nothing loaded gives one result, valid in the cycle after it is accepted.
// Synchronous active-low reset clears count, norms and control; no clearing pass.
module jacobi_column_pair_rotation #(
    parameter int COLUMN_DEPTH  = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // elem_j, elem_k, cross_term
    input  logic         s_tuser,  // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // rotated_j, rotated_k, cos_value, sin_value
    output logic         m_tlast,  // last
    output logic         m_tuser   // empty_res
);
    import jcpr_pkg::*;
    localparam int AW = (COLUMN_DEPTH > 1) ? $clog2(COLUMN_DEPTH) : 1;
    localparam int CW = $clog2(COLUMN_DEPTH + 1);
    localparam int EB = (ELEMENT_WIDTH > 32) ? 32 : ELEMENT_WIDTH;
    localparam logic signed [63:0] EHi = (64'sd1 <<< (EB - 1)) - 64'sd1;
    localparam logic signed [63:0] ELo = -EHi - 64'sd1;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [63:0] nf_reg, nf_next, ns_reg, ns_next;
    logic [63:0] ma_reg, ma_next, md_reg, md_next, tmp_reg, tmp_next;
    logic an_reg, an_next, dn_reg, dn_next, dz_reg, dz_next;
    logic signed [63:0] t_reg, t_next, c_reg, c_next, s_reg, s_next;
    logic signed [63:0] pa_reg, pa_next;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_w;
    logic signed [63:0] prod;
    logic lst_reg, lst_next, emp_reg, emp_next;
    logic signed [31:0] oj_reg, oj_next, ok_reg, ok_next;
    unit_ctl_t uctl;
    unit_sts_t usts;
    logic [63:0] ua, ub, ures;
    logic [31:0] rj, rk;
    logic signed [31:0] ej, ek;
    logic [31:0] mj, mk;
    logic [63:0] sqj, sqk, sumj, sumk;
    logic accept, we;
    logic signed [63:0] dval;

    function automatic logic signed [63:0] sat(input logic signed [63:0] v);
        begin
            sat = (v > EHi) ? EHi : ((v < ELo) ? ELo : v);
        end
    endfunction

    assign accept = s_tvalid && s_tready;
    assign ej = signed'(s_tdata[31:0] << (32 - EB)) >>> (32 - EB);
    assign ek = signed'(s_tdata[63:32] << (32 - EB)) >>> (32 - EB);
    assign dval = s_tdata[127:64];
    assign mj = ej[31] ? 32'(-ej) : 32'(ej);
    assign mk = ek[31] ? 32'(-ek) : 32'(ek);
    assign sqj = 64'(mj) * 64'(mj);
    assign sqk = 64'(mk) * 64'(mk);
    assign sumj = nf_reg + sqj;
    assign sumk = ns_reg + sqk;
    assign we = accept && !s_tuser && (cnt_reg < CW'(COLUMN_DEPTH));

    jcpr_ram #(.Width(32), .Depth(COLUMN_DEPTH)) u_ram_j (
        .aclk(aclk), .we(we), .waddr(cnt_reg[AW-1:0]), .wdata(ej),
        .raddr(idx_reg), .rdata(rj));
    jcpr_ram #(.Width(32), .Depth(COLUMN_DEPTH)) u_ram_k (
        .aclk(aclk), .we(we), .waddr(cnt_reg[AW-1:0]), .wdata(ek),
        .raddr(idx_reg), .rdata(rk));
    jcpr_unit u_unit (
        .aclk(aclk), .aresetn(aresetn), .ctl(uctl), .opa(ua), .opb(ub),
        .sts(usts), .res(ures));

    assign prod_w = mul_a * mul_b;
    assign prod = prod_w[63:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            nf_reg <= '0;
            ns_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            nf_reg <= nf_next;
            ns_reg <= ns_next;
        end
        idx_reg <= idx_next; ma_reg <= ma_next; md_reg <= md_next; tmp_reg <= tmp_next;
        an_reg <= an_next; dn_reg <= dn_next; dz_reg <= dz_next;
        t_reg <= t_next; c_reg <= c_next; s_reg <= s_next;
        pa_reg <= pa_next;
        lst_reg <= lst_next; emp_reg <= emp_next; oj_reg <= oj_next; ok_reg <= ok_next;
    end

    always_comb begin
        state_next = state_reg; cnt_next = cnt_reg; idx_next = idx_reg;
        nf_next = nf_reg; ns_next = ns_reg; ma_next = ma_reg; md_next = md_reg;
        tmp_next = tmp_reg; an_next = an_reg; dn_next = dn_reg; dz_next = dz_reg;
        t_next = t_reg; c_next = c_reg; s_next = s_reg; pa_next = pa_reg;
        lst_next = lst_reg; emp_next = emp_reg;
        oj_next = oj_reg; ok_next = ok_reg;
        uctl.op = OP_NONE; uctl.start = 1'b0; ua = 64'd0; ub = 64'd0;
        mul_a = 33'sd0; mul_b = 33'sd0;
        s_tready = 1'b0; m_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    if (!s_tuser) begin
                        if (we) begin
                            nf_next = (sumj < nf_reg) ? '1 : sumj;
                            ns_next = (sumk < ns_reg) ? '1 : sumk;
                            cnt_next = cnt_reg + CW'(1);
                        end
                    end else if (cnt_reg == '0) begin
                        emp_next = 1'b1; lst_next = 1'b1;
                        oj_next = '0; ok_next = '0; c_next = '0; s_next = '0;
                        nf_next = '0; ns_next = '0;
                        state_next = ST_OUT;
                    end else begin
                        emp_next = 1'b0;
                        an_next = ns_reg < nf_reg;
                        ma_next = (ns_reg < nf_reg) ? nf_reg - ns_reg : ns_reg - nf_reg;
                        dn_next = dval[63];
                        md_next = dval[63] ? 64'd0 - dval : dval;
                        dz_next = (dval == 64'sd0);
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                if (dz_reg) begin
                    t_next = 64'sd0;
                    state_next = ST_TSQ;
                end else if ((ma_reg | md_reg) >= 64'h4000_0000) begin
                    ma_next = ma_reg >> 1; md_next = md_reg >> 1;
                end else begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                mul_a = 33'(ma_reg); mul_b = 33'(ma_reg);
                tmp_next = prod;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                mul_a = 33'(md_reg); mul_b = 33'(md_reg);
                tmp_next = tmp_reg + (prod << 2);
                state_next = ST_SQRT1;
                pa_next = 64'sd0;
            end
            ST_SQRT1: begin
                if (pa_reg == 64'sd0) begin
                    uctl.start = 1'b1; uctl.op = OP_SQRT; ua = tmp_reg;
                    pa_next = 64'sd1;
                end else if (usts.done) begin
                    tmp_next = ma_reg + ures;
                    pa_next = 64'sd0;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (pa_reg == 64'sd0) begin
                    uctl.start = 1'b1; uctl.op = OP_DIV;
                    ua = ((md_reg << 31)) + (tmp_reg >> 1); ub = tmp_reg;
                    pa_next = 64'sd1;
                end else if (usts.done) begin
                    t_next = (ures > 64'h4000_0000) ? 64'sh4000_0000 : signed'(ures);
                    if (ma_reg != 64'd0 && (an_reg != dn_reg)) begin
                        t_next = -((ures > 64'h4000_0000) ? 64'sh4000_0000 : signed'(ures));
                    end
                    pa_next = 64'sd0;
                    state_next = ST_TSQ;
                end
            end
            ST_TSQ: begin
                mul_a = 33'(t_reg); mul_b = 33'(t_reg);
                tmp_next = 64'h1000_0000_0000_0000 + prod;
                pa_next = 64'sd0;
                state_next = ST_SQRT2;
            end
            ST_SQRT2: begin
                if (pa_reg == 64'sd0) begin
                    uctl.start = 1'b1; uctl.op = OP_SQRT; ua = tmp_reg;
                    pa_next = 64'sd1;
                end else if (usts.done) begin
                    tmp_next = ures;
                    pa_next = 64'sd0;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (pa_reg == 64'sd0) begin
                    uctl.start = 1'b1; uctl.op = OP_DIV;
                    ua = 64'h1000_0000_0000_0000 + (tmp_reg >> 1); ub = tmp_reg;
                    pa_next = 64'sd1;
                end else if (usts.done) begin
                    c_next = (ures > 64'h4000_0000) ? 64'sh4000_0000 : signed'(ures);
                    state_next = ST_SIN;
                end
            end
            ST_SIN: begin
                mul_a = 33'(t_reg); mul_b = 33'(c_reg);
                s_next = round30(prod);
                idx_next = '0;
                state_next = ST_RD;
            end
            ST_RD: begin
                state_next = ST_MJ;
            end
            ST_MJ: begin
                mul_a = 33'(c_reg); mul_b = 33'(signed'(rj));
                pa_next = prod;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                mul_a = 33'(s_reg); mul_b = 33'(signed'(rk));
                oj_next = 32'(sat(round30(pa_reg - prod)));
                state_next = ST_MK;
            end
            ST_MK: begin
                mul_a = 33'(s_reg); mul_b = 33'(signed'(rj));
                pa_next = prod;
                state_next = ST_EMPTY;
            end
            ST_EMPTY: begin
                mul_a = 33'(c_reg); mul_b = 33'(signed'(rk));
                ok_next = 32'(sat(round30(pa_reg + prod)));
                lst_next = (CW'(idx_reg) == cnt_reg - CW'(1));
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (lst_reg) begin
                        cnt_next = '0; nf_next = '0; ns_next = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tdata = {1'b0, s_reg[31:0], c_reg[30:0], ok_reg, oj_reg};
    assign m_tlast = lst_reg;
    assign m_tuser = emp_reg;
endmodule

/* design/jcpr_ram.sv */
`timescale 1ns / 1ps
module jcpr_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/jcpr_unit.sv */
`timescale 1ns / 1ps
// shared bit-serial sqrt / divide, one result bit per cycle
module jcpr_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  jcpr_pkg::unit_ctl_t  ctl,
    input  logic [63:0]          opa,
    input  logic [63:0]          opb,
    output jcpr_pkg::unit_sts_t  sts,
    output logic [63:0]          res
);
    import jcpr_pkg::*;
    logic [63:0]  x_reg, x_next, r_reg, r_next, b_reg, b_next, q_reg, q_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next, done_reg, done_next, sq_reg, sq_next;
    logic [64:0]  rem;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg <= x_next; r_reg <= r_next; b_reg <= b_next; q_reg <= q_next;
        cnt_reg <= cnt_next; sq_reg <= sq_next;
    end
    always_comb begin
        x_next = x_reg; r_next = r_reg; b_next = b_reg; q_next = q_reg;
        cnt_next = cnt_reg; sq_next = sq_reg; busy_next = busy_reg; done_next = 1'b0;
        rem = 65'd0;
        if (ctl.start) begin
            busy_next = 1'b1;
            sq_next = (ctl.op == OP_SQRT);
            x_next = opa;
            b_next = (ctl.op == OP_SQRT) ? 64'h4000_0000_0000_0000 : opb;
            r_next = 64'd0;
            q_next = 64'd0;
            cnt_next = (ctl.op == OP_SQRT) ? 7'd32 : 7'd64;
        end else if (busy_reg) begin
            if (sq_reg) begin
                if (x_reg >= r_reg + b_reg) begin
                    x_next = x_reg - (r_reg + b_reg);
                    r_next = (r_reg >> 1) + b_reg;
                end else begin
                    r_next = r_reg >> 1;
                end
                b_next = b_reg >> 2;
            end else begin
                rem = {r_reg, x_reg[63]};
                x_next = {x_reg[62:0], 1'b0};
                if (rem >= {1'b0, b_reg}) begin
                    r_next = 64'(rem - {1'b0, b_reg});
                    q_next = {q_reg[62:0], 1'b1};
                end else begin
                    r_next = rem[63:0];
                    q_next = {q_reg[62:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign res = sq_reg ? r_reg : q_reg;
endmodule

/* design/jcpr_checker.sv */
`timescale 1ns / 1ps
module jcpr_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tlast,
    input logic         m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready during output");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == 128'd0)
        else $error("empty result malformed");
    a_cos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[94:64] <= 31'h4000_0000)
        else $error("cosine out of range");
endmodule

bind jacobi_column_pair_rotation jcpr_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser));
